@@ src/mtdr_pkg.sv @@
// Package for the two-disjoint-rectangle maximum-sum block.
// Holds the shared widths, register indexes and the controller-to-datapath command word.
// No dependencies.
package mtdr_pkg;

    localparam int DEF_MAX_ROWS  = 8;
    localparam int DEF_MAX_COLS  = 8;
    localparam int DEF_CELL_BITS = 16;

    localparam int OUT_W      = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Field widths of the command word cover the largest grid allowed (32 by 32).
    localparam int IDX_W  = 5;
    localparam int ADDR_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              clr_max;
        logic              clr_col;
        logic              acc_col;
        logic              rect;
        logic              first;
        logic [IDX_W-1:0]  row_top;
        logic [IDX_W-1:0]  row_bot;
        logic [IDX_W-1:0]  col_lft;
        logic [IDX_W-1:0]  col_rgt;
        logic              rpre;
        logic              rsuf;
        logic              cpre;
        logic              csuf;
        logic [IDX_W-1:0]  pidx;
        logic              load_out;
        logic              no_pair;
    } t_cmd;

endpackage

@@ src/mtdr_ifs.sv @@
// Channel interfaces of the two-disjoint-rectangle maximum-sum block.
// Depends on mtdr_pkg for the result and configuration widths.
interface mtdr_in_if #(parameter int CELL_BITS = mtdr_pkg::DEF_CELL_BITS);
    logic                        valid;
    logic                        ready;
    logic signed [CELL_BITS-1:0] cell_value;
    logic                        last_cell;
    modport source (output valid, output cell_value, output last_cell, input ready);
    modport sink (input valid, input cell_value, input last_cell, output ready);
endinterface

interface mtdr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mtdr_pkg::OUT_W-1:0]  best_sum;
    logic                               no_pair;
    modport source (output valid, output best_sum, output no_pair, input ready);
    modport sink (input valid, input best_sum, input no_pair, output ready);
endinterface

interface mtdr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mtdr_pkg::CFG_IDX_W-1:0]    index;
    logic [mtdr_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/max_two_disjoint_rect_sum.sv @@
// Top level: largest sum of two disjoint rectangles in a streamed grid.
// Cells load at one word per cycle while the block is idle. After the word with last_cell is taken,
// for each top row the block reads each further row into the column sums, cell by cell, and scores
// every rectangle on that band of rows; then it runs the split scans and loads the result.
// Input is held off during the search; the result sits in an output register until taken.
// Synchronous active-low reset empties the load count, drops any pending word, sets counts to 8.
module max_two_disjoint_rect_sum #(
    parameter int MAX_ROWS  = mtdr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = mtdr_pkg::DEF_MAX_COLS,
    parameter int CELL_BITS = mtdr_pkg::DEF_CELL_BITS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    mtdr_in_if.sink     i_in,
    mtdr_out_if.source  o_out,
    mtdr_cfg_if.sink    i_cfg
);
    import mtdr_pkg::*;

    t_cmd cmd;

    mtdr_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last_cell (i_in.last_cell),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .o_cmd       (cmd)
    );

    mtdr_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cell_value (i_in.cell_value),
        .i_cmd        (cmd),
        .o_best_sum   (o_out.best_sum),
        .o_no_pair    (o_out.no_pair)
    );

endmodule

@@ src/mtdr_ctrl.sv @@
// Sequencer of the block: cell loading, rectangle enumeration and the split scans.
// Depends on mtdr_pkg for the command word and register indexes.
module mtdr_ctrl #(
    parameter int MAX_ROWS = mtdr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = mtdr_pkg::DEF_MAX_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_last_cell,
    output logic                             o_in_ready,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    input  logic                             i_cfg_valid,
    input  logic [mtdr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mtdr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_cfg_ready,
    output mtdr_pkg::t_cmd                   o_cmd
);
    import mtdr_pkg::*;

    localparam int CAP = MAX_ROWS * MAX_COLS;
    localparam int LW  = $clog2(CAP + 1);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW  = (RW > CW) ? RW : CW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLRMAX = 4'd1;
    localparam logic [3:0] S_CLRCOL = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_ACC    = 4'd4;
    localparam logic [3:0] S_RECT   = 4'd5;
    localparam logic [3:0] S_RPRE   = 4'd6;
    localparam logic [3:0] S_RSUF   = 4'd7;
    localparam logic [3:0] S_CPRE   = 4'd8;
    localparam logic [3:0] S_CSUF   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]            r_state, n_state;
    logic [CFG_DATA_W-1:0] r_rows_cfg, n_rows_cfg, r_cols_cfg, n_cols_cfg;
    logic [RW-1:0]         r_rows_m1, n_rows_m1, r_i, n_i, r_k, n_k;
    logic [CW-1:0]         r_cols_m1, n_cols_m1, r_j, n_j, r_l, n_l, r_c, n_c;
    logic [PW-1:0]         r_p, n_p;
    logic [LW-1:0]         r_load, n_load;
    logic                  r_out_valid, n_out_valid;
    logic                  in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows_cfg  <= CFG_DATA_W'(8);
            r_cols_cfg  <= CFG_DATA_W'(8);
            r_rows_m1   <= '0;
            r_cols_m1   <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_l         <= '0;
            r_c         <= '0;
            r_p         <= '0;
            r_load      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows_cfg  <= n_rows_cfg;
            r_cols_cfg  <= n_cols_cfg;
            r_rows_m1   <= n_rows_m1;
            r_cols_m1   <= n_cols_m1;
            r_i         <= n_i;
            r_k         <= n_k;
            r_j         <= n_j;
            r_l         <= n_l;
            r_c         <= n_c;
            r_p         <= n_p;
            r_load      <= n_load;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rows_cfg  = r_rows_cfg;
        n_cols_cfg  = r_cols_cfg;
        n_rows_m1   = r_rows_m1;
        n_cols_m1   = r_cols_m1;
        n_i         = r_i;
        n_k         = r_k;
        n_j         = r_j;
        n_l         = r_l;
        n_c         = r_c;
        n_p         = r_p;
        n_load      = r_load;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        o_cmd.wr_addr = ADDR_W'(r_load);
        o_cmd.rd_addr = ADDR_W'(int'(r_k) * (int'(r_cols_m1) + 1) + int'(r_c));
        o_cmd.row_top = IDX_W'(r_i);
        o_cmd.row_bot = IDX_W'(r_k);
        o_cmd.col_lft = IDX_W'(r_j);
        o_cmd.col_rgt = IDX_W'(r_l);
        o_cmd.pidx    = IDX_W'(r_p);

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW_COUNT: n_rows_cfg = i_cfg_data;
                REG_COL_COUNT: n_cols_cfg = i_cfg_data;
                default:       n_rows_cfg = r_rows_cfg;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (int'(r_load) < CAP) begin
                        o_cmd.wr_en = 1'b1;
                        n_load      = r_load + LW'(1);
                    end
                    if (i_last_cell) begin
                        n_load = '0;
                        // Out-of-range counts are clamped to 1..maximum.
                        if (r_rows_cfg == '0) begin
                            n_rows_m1 = '0;
                        end else if (int'(r_rows_cfg) > MAX_ROWS) begin
                            n_rows_m1 = RW'(MAX_ROWS - 1);
                        end else begin
                            n_rows_m1 = RW'(int'(r_rows_cfg) - 1);
                        end
                        if (r_cols_cfg == '0) begin
                            n_cols_m1 = '0;
                        end else if (int'(r_cols_cfg) > MAX_COLS) begin
                            n_cols_m1 = CW'(MAX_COLS - 1);
                        end else begin
                            n_cols_m1 = CW'(int'(r_cols_cfg) - 1);
                        end
                        n_state = S_CLRMAX;
                    end
                end
            end
            S_CLRMAX: begin
                o_cmd.clr_max = 1'b1;
                n_i           = '0;
                n_state       = S_CLRCOL;
            end
            S_CLRCOL: begin
                o_cmd.clr_col = 1'b1;
                n_k           = r_i;
                n_c           = '0;
                n_state       = S_RD;
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_col = 1'b1;
                o_cmd.col_rgt = IDX_W'(r_c);
                if (r_c == r_cols_m1) begin
                    n_j     = '0;
                    n_l     = '0;
                    n_state = S_RECT;
                end else begin
                    n_c     = r_c + CW'(1);
                    n_state = S_RD;
                end
            end
            S_RECT: begin
                o_cmd.rect  = 1'b1;
                o_cmd.first = (r_l == r_j);
                if (r_l != r_cols_m1) begin
                    n_l = r_l + CW'(1);
                end else if (r_j != r_cols_m1) begin
                    n_j = r_j + CW'(1);
                    n_l = r_j + CW'(1);
                end else if (r_k != r_rows_m1) begin
                    n_k     = r_k + RW'(1);
                    n_c     = '0;
                    n_state = S_RD;
                end else if (r_i != r_rows_m1) begin
                    n_i     = r_i + RW'(1);
                    n_state = S_CLRCOL;
                end else begin
                    n_p     = '0;
                    n_state = S_RPRE;
                end
            end
            S_RPRE: begin
                o_cmd.rpre  = 1'b1;
                o_cmd.first = (r_p == '0);
                if (r_p != PW'(r_rows_m1)) begin
                    n_p = r_p + PW'(1);
                end else if (r_rows_m1 == '0) begin
                    n_p     = '0;
                    n_state = S_CPRE;
                end else begin
                    n_state = S_RSUF;
                end
            end
            S_RSUF: begin
                o_cmd.rsuf  = 1'b1;
                o_cmd.first = (r_p == PW'(r_rows_m1));
                if (r_p == PW'(1)) begin
                    n_p     = '0;
                    n_state = S_CPRE;
                end else begin
                    n_p = r_p - PW'(1);
                end
            end
            S_CPRE: begin
                o_cmd.cpre  = 1'b1;
                o_cmd.first = (r_p == '0);
                if (r_p != PW'(r_cols_m1)) begin
                    n_p = r_p + PW'(1);
                end else if (r_cols_m1 == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CSUF;
                end
            end
            S_CSUF: begin
                o_cmd.csuf  = 1'b1;
                o_cmd.first = (r_p == PW'(r_cols_m1));
                if (r_p == PW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_p = r_p - PW'(1);
                end
            end
            S_DONE: begin
                // Wait here while an earlier word still sits in the output register.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.no_pair  = (r_rows_m1 == '0) && (r_cols_m1 == '0);
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ src/mtdr_dp.sv @@
// Datapath of the block: grid memory, column sums, per-edge maxima and the result register.
// Depends on mtdr_pkg; driven by the command word from mtdr_ctrl.
module mtdr_dp #(
    parameter int MAX_ROWS  = mtdr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = mtdr_pkg::DEF_MAX_COLS,
    parameter int CELL_BITS = mtdr_pkg::DEF_CELL_BITS
) (
    input  logic                               i_clk,
    input  logic signed [CELL_BITS-1:0]        i_cell_value,
    input  mtdr_pkg::t_cmd                     i_cmd,
    output logic signed [mtdr_pkg::OUT_W-1:0]  o_best_sum,
    output logic                               o_no_pair
);
    import mtdr_pkg::*;

    localparam int CAP    = MAX_ROWS * MAX_COLS;
    localparam int AW     = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW     = (RW > CW) ? RW : CW;
    localparam int SUM_W  = CELL_BITS + AW + 1;
    localparam int PAIR_W = SUM_W + 1;
    localparam int EXT_W  = ((PAIR_W > OUT_W) ? PAIR_W : OUT_W) + 1;

    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [PAIR_W-1:0] PAIR_MIN = {1'b1, {(PAIR_W-1){1'b0}}};
    localparam logic signed [EXT_W-1:0]  SAT_HI   = EXT_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0]  SAT_LO   = -EXT_W'(64'sd1 <<< (OUT_W - 1));

    logic signed [CELL_BITS-1:0] mem [CAP];
    logic signed [CELL_BITS-1:0] r_rdata;
    logic signed [SUM_W-1:0]     r_col [MAX_COLS];
    logic signed [SUM_W-1:0]     r_top [MAX_ROWS];
    logic signed [SUM_W-1:0]     r_bot [MAX_ROWS];
    logic signed [SUM_W-1:0]     r_lft [MAX_COLS];
    logic signed [SUM_W-1:0]     r_rgt [MAX_COLS];
    logic signed [SUM_W-1:0]     r_acc;
    logic signed [SUM_W-1:0]     r_run;
    logic signed [PAIR_W-1:0]    r_best;
    logic signed [OUT_W-1:0]     r_best_sum;
    logic                        r_no_pair;

    logic [RW-1:0]            ri, rk, rp, rpm1;
    logic [CW-1:0]            cj, cl, cp, cpm1;
    logic [PW-1:0]            pm1;
    logic signed [SUM_W-1:0]  acc_n;
    logic signed [SUM_W-1:0]  run_src, run_n;
    logic signed [SUM_W-1:0]  pair_lhs;
    logic signed [PAIR_W-1:0] cand;
    logic signed [EXT_W-1:0]  best_x;

    assign ri   = i_cmd.row_top[RW-1:0];
    assign rk   = i_cmd.row_bot[RW-1:0];
    assign cj   = i_cmd.col_lft[CW-1:0];
    assign cl   = i_cmd.col_rgt[CW-1:0];
    assign rp   = i_cmd.pidx[RW-1:0];
    assign cp   = i_cmd.pidx[CW-1:0];
    assign pm1  = i_cmd.pidx[PW-1:0] - PW'(1);
    assign rpm1 = pm1[RW-1:0];
    assign cpm1 = pm1[CW-1:0];

    assign acc_n = (i_cmd.first ? SUM_W'(0) : r_acc) + r_col[cl];

    // One scan step: a running maximum over the per-edge table selected by the command, and the pair sum it forms.
    always_comb begin
        priority if (i_cmd.rpre) begin
            run_src  = r_bot[rp];
            pair_lhs = r_bot[rp];
        end else if (i_cmd.rsuf) begin
            run_src  = r_top[rp];
            pair_lhs = r_bot[rpm1];
        end else if (i_cmd.cpre) begin
            run_src  = r_rgt[cp];
            pair_lhs = r_rgt[cp];
        end else begin
            run_src  = r_lft[cp];
            pair_lhs = r_rgt[cpm1];
        end
        run_n = (i_cmd.first || run_src > r_run) ? run_src : r_run;
        cand  = PAIR_W'(pair_lhs) + PAIR_W'(run_n);
    end

    assign best_x = EXT_W'(r_best);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr[AW-1:0]] <= i_cell_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_cmd.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_max) begin
            for (int n = 0; n < MAX_ROWS; n++) begin
                r_top[n] <= SUM_MIN;
                r_bot[n] <= SUM_MIN;
            end
            for (int n = 0; n < MAX_COLS; n++) begin
                r_lft[n] <= SUM_MIN;
                r_rgt[n] <= SUM_MIN;
            end
            r_best <= PAIR_MIN;
        end
        if (i_cmd.clr_col) begin
            for (int n = 0; n < MAX_COLS; n++) begin
                r_col[n] <= '0;
            end
        end
        if (i_cmd.acc_col) begin
            r_col[cl] <= r_col[cl] + SUM_W'(r_rdata);
        end
        if (i_cmd.rect) begin
            r_acc <= acc_n;
            if (acc_n > r_top[ri]) begin
                r_top[ri] <= acc_n;
            end
            if (acc_n > r_bot[rk]) begin
                r_bot[rk] <= acc_n;
            end
            if (acc_n > r_lft[cj]) begin
                r_lft[cj] <= acc_n;
            end
            if (acc_n > r_rgt[cl]) begin
                r_rgt[cl] <= acc_n;
            end
        end
        // The prefix scans overwrite each entry with the best rectangle ending at or before it.
        if (i_cmd.rpre) begin
            r_run     <= run_n;
            r_bot[rp] <= run_n;
        end
        if (i_cmd.cpre) begin
            r_run     <= run_n;
            r_rgt[cp] <= run_n;
        end
        if (i_cmd.rsuf || i_cmd.csuf) begin
            r_run <= run_n;
            if (cand > r_best) begin
                r_best <= cand;
            end
        end
        if (i_cmd.load_out) begin
            r_no_pair <= i_cmd.no_pair;
            if (i_cmd.no_pair) begin
                r_best_sum <= '0;
            end else if (best_x > SAT_HI) begin
                r_best_sum <= OUT_W'(SAT_HI);
            end else if (best_x < SAT_LO) begin
                r_best_sum <= OUT_W'(SAT_LO);
            end else begin
                r_best_sum <= OUT_W'(best_x);
            end
        end
    end

    assign o_best_sum = r_best_sum;
    assign o_no_pair  = r_no_pair;

endmodule

@@ sim/tb_top.sv @@
// Testbench for the two-disjoint-rectangle maximum-sum block: streams grids, predicts results.
// Depends on mtdr_pkg and the channel interfaces in src/mtdr_ifs.sv.
`timescale 1ns / 100ps

class rect_pair_scoreboard;
    logic signed [15:0] cells[64];
    int unsigned loaded;
    logic [3:0] rows_reg;
    logic [3:0] cols_reg;
    logic signed [22:0] want_sum[$];
    bit want_none[$];
    int errors;

    function void clear();
        loaded = 0;
        rows_reg = 4'd8;
        cols_reg = 4'd8;
        errors = 0;
        foreach (cells[i]) cells[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [3:0] val);
        if (idx == mtdr_pkg::REG_ROW_COUNT) rows_reg = val;
        else cols_reg = val;
    endfunction

    // Brute force over every rectangle pair that sits apart by rows or by columns.
    function void best_pair(int nr, int nc);
        longint ps[0:8][0:8];
        longint s1, s2, top;
        bit found;
        int a, b, c, d, e, f, g, h;
        found = 0;
        top = 0;
        for (a = 0; a <= 8; a++)
            for (b = 0; b <= 8; b++) ps[a][b] = 0;
        for (a = 0; a < nr; a++)
            for (b = 0; b < nc; b++)
                ps[a+1][b+1] = ps[a][b+1] + ps[a+1][b] - ps[a][b] + cells[(a*nc+b) % 64];
        for (a = 0; a < nr; a++) for (b = 0; b < nc; b++)
        for (c = a; c < nr; c++) for (d = b; d < nc; d++) begin
            s1 = ps[c+1][d+1] - ps[a][d+1] - ps[c+1][b] + ps[a][b];
            for (e = 0; e < nr; e++) for (f = 0; f < nc; f++)
            for (g = e; g < nr; g++) for (h = f; h < nc; h++) begin
                if (g < a || h < b) begin
                    s2 = ps[g+1][h+1] - ps[e][h+1] - ps[g+1][f] + ps[e][f];
                    if (!found || s1 + s2 > top) begin
                        top = s1 + s2;
                        found = 1;
                    end
                end
            end
        end
        if (!found) begin
            want_sum.push_back('0);
            want_none.push_back(1'b1);
        end else begin
            if (top > 4194303) top = 4194303;
            if (top < -4194304) top = -4194304;
            want_sum.push_back(top[22:0]);
            want_none.push_back(1'b0);
        end
    endfunction

    function void note_cell(logic signed [15:0] v, logic last);
        int nr, nc;
        if (loaded < 64) begin
            cells[loaded] = v;
            loaded++;
        end
        if (last) begin
            nr = (rows_reg == 0) ? 1 : (rows_reg > 8 ? 8 : int'(rows_reg));
            nc = (cols_reg == 0) ? 1 : (cols_reg > 8 ? 8 : int'(cols_reg));
            loaded = 0;
            best_pair(nr, nc);
        end
    endfunction

    function void check_result(logic signed [22:0] got_sum, logic got_none);
        logic signed [22:0] es;
        bit en;
        if (want_sum.size() == 0) begin
            $display("%0t: unexpected word sum=%0d no_pair=%0b", $time, got_sum, got_none);
            errors++;
            return;
        end
        es = want_sum.pop_front();
        en = want_none.pop_front();
        if (got_none !== en) begin
            $display("%0t: no_pair expected %0b actual %0b", $time, en, got_none);
            errors++;
        end
        if (got_sum !== es) begin
            $display("%0t: best_sum expected %0d actual %0d", $time, es, got_sum);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic i_clk;
    logic i_rst_n;
    int unsigned cycle_cnt;
    int unsigned idle_pct;
    rect_pair_scoreboard board;

    mtdr_in_if  cell_ch();
    mtdr_out_if sum_ch();
    mtdr_cfg_if reg_ch();

    max_two_disjoint_rect_sum dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cell_ch.sink), .o_out(sum_ch.source),
        .i_cfg(reg_ch.sink)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 3000000) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls, check on each accepted word.
    initial begin
        sum_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sum_ch.valid && sum_ch.ready)
                board.check_result(sum_ch.best_sum, sum_ch.no_pair);
            sum_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Valid may drop for random idle gaps between words; the caller drops it after the last word.
    task automatic send_cell(logic signed [15:0] v, logic last);
        while ($urandom_range(99) < idle_pct) begin
            cell_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_ch.valid <= 1'b1;
        cell_ch.cell_value <= v;
        cell_ch.last_cell <= last;
        do @(posedge i_clk); while (!cell_ch.ready);
        board.note_cell(v, last);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data <= val;
        do @(posedge i_clk); while (!reg_ch.ready);
        board.set_reg(idx, val);
    endtask

    task automatic drain();
        while (board.want_sum.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // The grid must be complete; extra cells beyond rows*cols are allowed.
    task automatic send_grid(int n, int mode);
        logic signed [15:0] v;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: v = 16'($urandom);
                1: v = 16'sh7fff;
                2: v = 16'sh8000;
                default: v = $signed(16'($urandom_range(40))) - 16'sd20;
            endcase
            send_cell(v, k == n - 1);
        end
        cell_ch.valid <= 1'b0;
    endtask

    task automatic set_size(logic [3:0] r, logic [3:0] c);
        write_reg(mtdr_pkg::REG_ROW_COUNT, r);
        write_reg(mtdr_pkg::REG_COL_COUNT, c);
        reg_ch.valid <= 1'b0;
    endtask

    function automatic int eff(logic [3:0] x);
        return (x == 0) ? 1 : (x > 8 ? 8 : int'(x));
    endfunction

    int sent;
    logic [3:0] rr, cc;

    initial begin
        board = new();
        board.clear();
        idle_pct = 19;
        i_rst_n = 1'b0;
        cell_ch.valid = 1'b0;
        cell_ch.cell_value = '0;
        cell_ch.last_cell = 1'b0;
        reg_ch.valid = 1'b0;
        reg_ch.index = mtdr_pkg::REG_ROW_COUNT;
        reg_ch.data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes at full size, one-cell grid, out-of-range counts, extra cells.
        send_grid(64, 1);
        drain();
        send_grid(64, 2);
        drain();
        set_size(4'd0, 4'd0);
        send_grid(1, 0);
        drain();
        set_size(4'd15, 4'd1);
        send_grid(8, 0);
        drain();
        set_size(4'd1, 4'd2);
        send_grid(5, 0);
        drain();
        set_size(4'd2, 4'd9);
        send_grid(16, 2);
        drain();

        // Random grids, mostly small; one stretch runs without stalls.
        sent = 0;
        while (sent < 490) begin
            idle_pct = (sent > 200 && sent < 320) ? 0 : 19;
            if ($urandom_range(9) == 0) begin
                rr = 4'($urandom);
                cc = 4'($urandom);
            end else begin
                rr = 4'($urandom_range(4, 1));
                cc = 4'($urandom_range(4, 1));
            end
            set_size(rr, cc);
            send_grid(eff(rr) * eff(cc) + (($urandom_range(7) == 0) ? 2 : 0),
                      $urandom_range(3));
            sent += eff(rr) * eff(cc);
            drain();
        end
        idle_pct = 19;
        drain();
        if (board.errors == 0 && board.want_sum.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
